// ----- sv/ascon_aead128_engine_assert.svh -----
// Assertion macros used by the Ascon-AEAD128 engine top level.
`ifndef ASCON_AEAD128_ENGINE_ASSERT_SVH
`define ASCON_AEAD128_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ASCON_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASCON_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ascon_pkg.sv -----
// Types, codes and helper functions of the Ascon-AEAD128 engine.
package ascon_pkg;

	typedef logic [4:0][63:0] state_t;

	localparam logic [63:0] ASCON_IV   = 64'h0000_1000_808c_0001;
	localparam logic [63:0] ASCON_DSEP = 64'h8000_0000_0000_0000;

	localparam logic [1:0] KIND_NONCE = 2'd0;
	localparam logic [1:0] KIND_AD    = 2'd1;
	localparam logic [1:0] KIND_MSG   = 2'd2;
	localparam logic [1:0] KIND_TAG   = 2'd3;

	localparam logic [1:0] RES_DATA    = 2'd0;
	localparam logic [1:0] RES_TAG     = 2'd1;
	localparam logic [1:0] RES_VERDICT = 2'd2;

	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_AD       = 2'd1;
	localparam logic [1:0] PH_MSG      = 2'd2;
	localparam logic [1:0] PH_WAIT_TAG = 2'd3;

	localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
	localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
	localparam logic [1:0] CFG_MODE     = 2'd2;

	localparam logic [3:0] LAST_ROUND = 4'd11;
	localparam logic [3:0] ROUND_P12  = 4'd0;
	localparam logic [3:0] ROUND_P8   = 4'd4;

	function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
		return (v >> n) | (v << (64 - n));
	endfunction

	function automatic logic [7:0] round_const(input logic [3:0] r);
		return {~r, r};
	endfunction

	function automatic logic [127:0] byte_mask(input logic [4:0] n);
		logic [127:0] m;
		for (int i = 0; i < 16; i++) begin
			m[8*i +: 8] = (5'(i) < n) ? 8'hff : 8'h00;
		end
		return m;
	endfunction

	function automatic logic [127:0] pad_bit(input logic [4:0] n);
		logic [127:0] p;
		p = '0;
		for (int i = 0; i < 16; i++) begin
			p[8*i] = (5'(i) == n);
		end
		return p;
	endfunction

endpackage

// ----- sv/ascon_round.sv -----
// One round of the Ascon permutation: constant addition, S-box layer, linear layer.
module ascon_perm_round (
	input  ascon_pkg::state_t   lanes_in,
	input  logic [7:0]          rc,
	output ascon_pkg::state_t   lanes_out
);
	import ascon_pkg::*;

	logic [63:0] a0, a1, a2, a3, a4;
	logic [63:0] s0, s1, s2, s3, s4;
	logic [63:0] t0, t1, t2, t3, t4;

	always_comb begin
		a0 = lanes_in[0] ^ lanes_in[4];
		a4 = lanes_in[4] ^ lanes_in[3];
		a2 = lanes_in[2] ^ {56'd0, rc} ^ lanes_in[1];
		a1 = lanes_in[1];
		a3 = lanes_in[3];
		s0 = a0 ^ (~a1 & a2);
		s1 = a1 ^ (~a2 & a3);
		s2 = a2 ^ (~a3 & a4);
		s3 = a3 ^ (~a4 & a0);
		s4 = a4 ^ (~a0 & a1);
		t1 = s1 ^ s0;
		t0 = s0 ^ s4;
		t3 = s3 ^ s2;
		t2 = ~s2;
		t4 = s4;
		lanes_out[0] = t0 ^ rotr(t0, 19) ^ rotr(t0, 28);
		lanes_out[1] = t1 ^ rotr(t1, 61) ^ rotr(t1, 39);
		lanes_out[2] = t2 ^ rotr(t2, 1) ^ rotr(t2, 6);
		lanes_out[3] = t3 ^ rotr(t3, 10) ^ rotr(t3, 17);
		lanes_out[4] = t4 ^ rotr(t4, 7) ^ rotr(t4, 41);
	end

endmodule

// ----- sv/ascon_aead128_engine.sv -----
// Top level of the Ascon-AEAD128 engine: sequencer, one shared round unit and result register.
// Absorbed block: accept, decode, 8 rounds, finish. A final message block or an ignored item
// returns to idle from decode, where a message result is registered. Nonce and tag items run
// 12 rounds; closing open associated data adds a padding permutation of 8 rounds, or a second
// decode when no block was absorbed. A result waiting in the output register stalls the next result.
// Asynchronous active-low reset clears keys, mode, lanes, phase and all control state.
`include "ascon_aead128_engine_assert.svh"

module ascon_aead128_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [63:0] word_low,
	input  logic [63:0] word_high,
	input  logic [4:0]  byte_count,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [63:0] data_low,
	output logic [63:0] data_high,
	output logic [4:0]  out_count,
	output logic        auth_ok
);
	import ascon_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DECODE = 2'd1;
	localparam logic [1:0] ST_PERM   = 2'd2;
	localparam logic [1:0] ST_FIN    = 2'd3;

	localparam logic [2:0] AFT_NONE    = 3'd0;
	localparam logic [2:0] AFT_NONCE   = 3'd1;
	localparam logic [2:0] AFT_AD_FULL = 3'd2;
	localparam logic [2:0] AFT_AD_LAST = 3'd3;
	localparam logic [2:0] AFT_CLOSE   = 3'd4;
	localparam logic [2:0] AFT_TAG     = 3'd5;

	logic [63:0]  key_low_q, key_high_q;
	logic         dec_q;
	state_t       lanes_q;
	logic [1:0]   phase_q;
	logic         data_seen_q;
	logic [1:0]   state_q;
	logic [3:0]   round_q;
	logic [2:0]   after_q;
	logic [1:0]   kind_q;
	logic [127:0] word_q;
	logic [4:0]   cnt_q;
	logic         last_q;

	logic         out_valid_q;
	logic [1:0]   result_kind_q;
	logic [127:0] data_q;
	logic [4:0]   out_count_q;
	logic         auth_ok_q;

	state_t       round_out;
	logic [4:0]   n_c;
	logic [127:0] mask_c, pad_c, blk_c, wm_c, ad_blk_c, msg_blk_c, msg_out_c;
	logic [127:0] tag_c;
	logic         out_free_c;
	logic         out_load_c;

	ascon_perm_round u_round (
		.lanes_in  (lanes_q),
		.rc        (round_const(round_q)),
		.lanes_out (round_out)
	);

	always_comb begin
		if (!last_q) begin
			n_c = 5'd16;
		end else if (cnt_q > 5'd15) begin
			n_c = 5'd15;
		end else begin
			n_c = cnt_q;
		end
		mask_c   = byte_mask(n_c);
		pad_c    = last_q ? pad_bit(n_c) : 128'd0;
		blk_c    = {lanes_q[1], lanes_q[0]};
		wm_c     = word_q & mask_c;
		ad_blk_c = blk_c ^ wm_c ^ pad_c;
		if (dec_q) begin
			msg_out_c = (blk_c ^ wm_c) & mask_c;
			msg_blk_c = ((blk_c & ~mask_c) | wm_c) ^ pad_c;
		end else begin
			msg_out_c = (blk_c ^ wm_c) & mask_c;
			msg_blk_c = blk_c ^ wm_c ^ pad_c;
		end
		tag_c      = {lanes_q[4] ^ key_high_q, lanes_q[3] ^ key_low_q};
		out_free_c = !out_valid_q || out_ready;
		out_load_c = out_free_c &&
			((state_q == ST_DECODE && kind_q == KIND_MSG && phase_q == PH_MSG) ||
			(state_q == ST_FIN && after_q == AFT_TAG));
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign result_kind = result_kind_q;
	assign data_low    = data_q[63:0];
	assign data_high   = data_q[127:64];
	assign out_count   = out_count_q;
	assign auth_ok     = auth_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q     <= '0;
			key_high_q    <= '0;
			dec_q         <= 1'b0;
			lanes_q       <= '0;
			phase_q       <= PH_IDLE;
			data_seen_q   <= 1'b0;
			state_q       <= ST_IDLE;
			round_q       <= '0;
			after_q       <= AFT_NONE;
			kind_q        <= KIND_NONCE;
			word_q        <= '0;
			cnt_q         <= '0;
			last_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			result_kind_q <= RES_DATA;
			data_q        <= '0;
			out_count_q   <= '0;
			auth_ok_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_KEY_LOW:  key_low_q <= cfg_data;
					CFG_KEY_HIGH: key_high_q <= cfg_data;
					CFG_MODE:     dec_q <= cfg_data[0];
					default:      ;
				endcase
			end
			if (out_valid_q && out_ready && !out_load_c) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind;
						word_q  <= {word_high, word_low};
						cnt_q   <= byte_count;
						last_q  <= last;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (kind_q == KIND_NONCE) begin
						lanes_q[0] <= ASCON_IV;
						lanes_q[1] <= key_low_q;
						lanes_q[2] <= key_high_q;
						lanes_q[3] <= word_q[63:0];
						lanes_q[4] <= word_q[127:64];
						round_q    <= ROUND_P12;
						after_q    <= AFT_NONCE;
						state_q    <= ST_PERM;
					end else if (phase_q == PH_IDLE) begin
						state_q <= ST_IDLE;
					end else if (kind_q == KIND_AD) begin
						if (phase_q != PH_AD) begin
							state_q <= ST_IDLE;
						end else if (!last_q || n_c != 5'd0 || data_seen_q) begin
							{lanes_q[1], lanes_q[0]} <= ad_blk_c;
							round_q <= ROUND_P8;
							after_q <= last_q ? AFT_AD_LAST : AFT_AD_FULL;
							state_q <= ST_PERM;
						end else begin
							lanes_q[4] <= lanes_q[4] ^ ASCON_DSEP;
							phase_q    <= PH_MSG;
							state_q    <= ST_IDLE;
						end
					end else if (phase_q == PH_AD) begin
						if (data_seen_q) begin
							lanes_q[0] <= lanes_q[0] ^ 64'd1;
							round_q    <= ROUND_P8;
							after_q    <= AFT_CLOSE;
							state_q    <= ST_PERM;
						end else begin
							lanes_q[4] <= lanes_q[4] ^ ASCON_DSEP;
							phase_q    <= PH_MSG;
						end
					end else if (kind_q == KIND_MSG) begin
						if (phase_q != PH_MSG) begin
							state_q <= ST_IDLE;
						end else if (out_free_c) begin
							out_valid_q   <= 1'b1;
							result_kind_q <= RES_DATA;
							data_q        <= msg_out_c;
							out_count_q   <= n_c;
							auth_ok_q     <= 1'b0;
							{lanes_q[1], lanes_q[0]} <= msg_blk_c;
							if (last_q) begin
								phase_q <= PH_WAIT_TAG;
								state_q <= ST_IDLE;
							end else begin
								round_q <= ROUND_P8;
								after_q <= AFT_NONE;
								state_q <= ST_PERM;
							end
						end
					end else begin
						lanes_q[0] <= lanes_q[0] ^ {63'd0, phase_q == PH_MSG};
						lanes_q[2] <= lanes_q[2] ^ key_low_q;
						lanes_q[3] <= lanes_q[3] ^ key_high_q;
						round_q    <= ROUND_P12;
						after_q    <= AFT_TAG;
						state_q    <= ST_PERM;
					end
				end
				ST_PERM: begin
					lanes_q <= round_out;
					round_q <= round_q + 4'd1;
					if (round_q == LAST_ROUND) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					unique case (after_q)
						AFT_NONCE: begin
							lanes_q[3]  <= lanes_q[3] ^ key_low_q;
							lanes_q[4]  <= lanes_q[4] ^ key_high_q;
							phase_q     <= PH_AD;
							data_seen_q <= 1'b0;
							state_q     <= ST_IDLE;
						end
						AFT_AD_FULL: begin
							data_seen_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
						AFT_AD_LAST: begin
							lanes_q[4] <= lanes_q[4] ^ ASCON_DSEP;
							phase_q    <= PH_MSG;
							state_q    <= ST_IDLE;
						end
						AFT_CLOSE: begin
							lanes_q[4] <= lanes_q[4] ^ ASCON_DSEP;
							phase_q    <= PH_MSG;
							state_q    <= ST_DECODE;
						end
						AFT_TAG: begin
							if (out_free_c) begin
								out_valid_q <= 1'b1;
								if (dec_q) begin
									result_kind_q <= RES_VERDICT;
									data_q        <= '0;
									out_count_q   <= 5'd0;
									auth_ok_q     <= (tag_c == word_q);
								end else begin
									result_kind_q <= RES_TAG;
									data_q        <= tag_c;
									out_count_q   <= 5'd16;
									auth_ok_q     <= 1'b0;
								end
								lanes_q     <= '0;
								phase_q     <= PH_IDLE;
								data_seen_q <= 1'b0;
								state_q     <= ST_IDLE;
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASCON_ASSERT_NEXT(a_accept_decodes, in_valid && in_ready, state_q == ST_DECODE, "accepted item did not reach decode")
	`ASCON_ASSERT_NOW(a_round_range, state_q == ST_PERM, round_q <= LAST_ROUND, "round counter out of range")
	`ASCON_ASSERT_NEXT(a_result_held, out_valid_q && !out_ready, out_valid_q && $stable(data_q) && $stable(result_kind_q), "pending result overwritten")
	`ASCON_ASSERT_NEXT(a_tag_clears, state_q == ST_FIN && after_q == AFT_TAG && out_free_c, phase_q == PH_IDLE && lanes_q == '0 && out_valid_q, "tag finish did not clear state")

endmodule

// ----- test/ascon_result_checker.sv -----
// Checker that predicts the Ascon-AEAD128 engine results from accepted items and compares them.
`timescale 1ns / 1ps

module ascon_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [63:0] word_low,
	input  logic [63:0] word_high,
	input  logic [4:0]  byte_count,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  result_kind,
	input  logic [63:0] data_low,
	input  logic [63:0] data_high,
	input  logic [4:0]  out_count,
	input  logic        auth_ok,
	output int          fail_count,
	output int          pending
);
	import ascon_pkg::*;

	typedef struct packed {
		logic [1:0]  rkind;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  cnt;
		logic        ok;
	} result_t;

	logic [63:0] key_lo_q;
	logic [63:0] key_hi_q;
	logic        dec_q;
	logic [63:0] st [5];
	logic [1:0]  ph;
	logic        ad_seen;
	result_t     owed_q[$];

	function automatic logic [63:0] rot(input logic [63:0] v, input int n);
		logic [127:0] d;
		d = {v, v} >> n;
		return d[63:0];
	endfunction

	function automatic logic [127:0] low_bytes(input int n);
		logic [127:0] m;
		m = '1;
		if (n < 16) begin
			m = (128'd1 << (8 * n)) - 128'd1;
		end
		return m;
	endfunction

	function automatic logic [127:0] pad_one(input int n);
		return 128'd1 << (8 * n);
	endfunction

	task automatic model_round(input logic [3:0] r);
		logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
		x0 = st[0];
		x1 = st[1];
		x2 = st[2] ^ {56'd0, 4'(4'd15 - r), r};
		x3 = st[3];
		x4 = st[4];
		x0 ^= x4;
		x4 ^= x3;
		x2 ^= x1;
		t0 = x0 ^ (~x1 & x2);
		t1 = x1 ^ (~x2 & x3);
		t2 = x2 ^ (~x3 & x4);
		t3 = x3 ^ (~x4 & x0);
		t4 = x4 ^ (~x0 & x1);
		t1 ^= t0;
		t0 ^= t4;
		t3 ^= t2;
		t2 = ~t2;
		st[0] = t0 ^ rot(t0, 19) ^ rot(t0, 28);
		st[1] = t1 ^ rot(t1, 61) ^ rot(t1, 39);
		st[2] = t2 ^ rot(t2, 1) ^ rot(t2, 6);
		st[3] = t3 ^ rot(t3, 10) ^ rot(t3, 17);
		st[4] = t4 ^ rot(t4, 7) ^ rot(t4, 41);
	endtask

	task automatic permute(input int rounds);
		for (int r = 12 - rounds; r < 12; r++) begin
			model_round(4'(r));
		end
	endtask

	task automatic xor_rate(input logic [127:0] v);
		st[0] ^= v[63:0];
		st[1] ^= v[127:64];
	endtask

	task automatic finish_ad();
		if (ad_seen) begin
			xor_rate(pad_one(0));
			permute(8);
		end
		st[4] ^= ASCON_DSEP;
		ph = PH_MSG;
	endtask

	task automatic predict_item(input logic [1:0] k, input logic [63:0] w0, input logic [63:0] w1,
			input logic [4:0] cnt, input logic lst);
		int n;
		logic [127:0] m, w, o, tag;
		result_t res;
		if (k == KIND_NONCE) begin
			st[0] = ASCON_IV;
			st[1] = key_lo_q;
			st[2] = key_hi_q;
			st[3] = w0;
			st[4] = w1;
			permute(12);
			st[3] ^= key_lo_q;
			st[4] ^= key_hi_q;
			ph = PH_AD;
			ad_seen = 1'b0;
		end else if (ph != PH_IDLE) begin
			n = lst ? ((cnt > 5'd15) ? 15 : int'(cnt)) : 16;
			m = low_bytes(n);
			w = {w1, w0} & m;
			case (k)
				KIND_AD: begin
					if (ph == PH_AD) begin
						if (!lst) begin
							xor_rate(w);
							permute(8);
							ad_seen = 1'b1;
						end else begin
							if (n != 0 || ad_seen) begin
								xor_rate(w);
								xor_rate(pad_one(n));
								permute(8);
							end
							st[4] ^= ASCON_DSEP;
							ph = PH_MSG;
						end
					end
				end
				KIND_MSG: begin
					if (ph == PH_AD) begin
						finish_ad();
					end
					if (ph == PH_MSG) begin
						if (dec_q) begin
							o = ({st[1], st[0]} ^ w) & m;
							{st[1], st[0]} = ({st[1], st[0]} & ~m) | w;
						end else begin
							xor_rate(w);
							o = {st[1], st[0]} & m;
						end
						if (lst) begin
							xor_rate(pad_one(n));
							ph = PH_WAIT_TAG;
						end else begin
							permute(8);
						end
						res = '{RES_DATA, o[63:0], o[127:64], 5'(n), 1'b0};
						owed_q.push_back(res);
					end
				end
				default: begin
					if (ph == PH_AD) begin
						finish_ad();
					end
					if (ph == PH_MSG) begin
						xor_rate(pad_one(0));
					end
					st[2] ^= key_lo_q;
					st[3] ^= key_hi_q;
					permute(12);
					tag = {st[4] ^ key_hi_q, st[3] ^ key_lo_q};
					if (dec_q) begin
						res = '{RES_VERDICT, 64'd0, 64'd0, 5'd0, (tag == {w1, w0})};
					end else begin
						res = '{RES_TAG, tag[63:0], tag[127:64], 5'd16, 1'b0};
					end
					owed_q.push_back(res);
					for (int i = 0; i < 5; i++) begin
						st[i] = '0;
					end
					ph = PH_IDLE;
					ad_seen = 1'b0;
				end
			endcase
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("ERROR %0t ns: %s got %h expected %h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			key_lo_q = '0;
			key_hi_q = '0;
			dec_q = 1'b0;
			for (int i = 0; i < 5; i++) begin
				st[i] = '0;
			end
			ph = PH_IDLE;
			ad_seen = 1'b0;
			owed_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_LOW: key_lo_q = cfg_data;
					CFG_KEY_HIGH: key_hi_q = cfg_data;
					CFG_MODE: dec_q = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				predict_item(kind, word_low, word_high, byte_count, last);
			end
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					report_mismatch("result with none owed, data_low", data_low, 64'd0);
				end else begin
					e = owed_q.pop_front();
					if (result_kind !== e.rkind) begin
						report_mismatch("result_kind", 64'(result_kind), 64'(e.rkind));
					end
					if (data_low !== e.lo) begin
						report_mismatch("data_low", data_low, e.lo);
					end
					if (data_high !== e.hi) begin
						report_mismatch("data_high", data_high, e.hi);
					end
					if (out_count !== e.cnt) begin
						report_mismatch("out_count", 64'(out_count), 64'(e.cnt));
					end
					if (auth_ok !== e.ok) begin
						report_mismatch("auth_ok", 64'(auth_ok), 64'(e.ok));
					end
				end
			end
			pending = owed_q.size();
		end
	end

endmodule

// ----- test/tb.sv -----
// Testbench top for the Ascon-AEAD128 engine: stimulus, handshake pacing and the verdict.
`timescale 1ns / 1ps

module tb;
	import ascon_pkg::*;

	typedef struct packed {
		logic [1:0]  k;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  cnt;
		logic        lst;
	} block_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [63:0] word_low;
	logic [63:0] word_high;
	logic [4:0]  byte_count;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  result_kind;
	logic [63:0] data_low;
	logic [63:0] data_high;
	logic [4:0]  out_count;
	logic        auth_ok;
	int          fail_count;
	int          pending;

	int          burst_left;
	int          hold_ask;
	int          hold_seen;
	int          hold_left;
	int          style;
	int          style_left;
	block_t      sent_log[$];
	logic [127:0] got_q[$];

	ascon_aead128_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .word_low(word_low), .word_high(word_high),
		.byte_count(byte_count), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .data_low(data_low), .data_high(data_high),
		.out_count(out_count), .auth_ok(auth_ok)
	);

	ascon_result_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .word_low(word_low), .word_high(word_high),
		.byte_count(byte_count), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .data_low(data_low), .data_high(data_high),
		.out_count(out_count), .auth_ok(auth_ok),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	// The receiver keeps its own stall pattern; a long hold-off is requested by bumping hold_ask.
	initial begin
		out_ready = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		style_left = 0;
		style = 0;
	end

	always @(negedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen = hold_ask;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				style = $urandom_range(0, 2);
				style_left = $urandom_range(30, 200);
			end
			style_left--;
			case (style)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_q.push_back({data_high, data_low});
		end
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic block_t mk(input logic [1:0] k, input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] cnt, input logic lst);
		block_t b;
		b = '{k, lo, hi, cnt, lst};
		return b;
	endfunction

	task automatic send_item(input block_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= b.k;
		word_low <= b.lo;
		word_high <= b.hi;
		byte_count <= b.cnt;
		last <= b.lst;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic send_rec(input block_t b);
		sent_log.push_back(b);
		send_item(b);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (40) @(negedge clk);
	endtask

	task automatic configure(input logic [63:0] klo, input logic [63:0] khi, input logic mode);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_KEY_LOW;
		cfg_data <= klo;
		@(negedge clk);
		cfg_index <= CFG_KEY_HIGH;
		cfg_data <= khi;
		@(negedge clk);
		cfg_index <= CFG_MODE;
		cfg_data <= {63'd0, mode};
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_stream();
		int n_ad, n_msg;
		send_rec(mk(KIND_NONCE, rnd64(), rnd64(), 5'($urandom_range(0, 16)), 1'($urandom)));
		n_ad = $urandom_range(0, 3);
		repeat (n_ad) send_rec(mk(KIND_AD, rnd64(), rnd64(), 5'($urandom_range(0, 16)), 1'b0));
		if ($urandom_range(0, 3) != 0) begin
			send_rec(mk(KIND_AD, rnd64(), rnd64(), 5'($urandom_range(0, 16)), 1'b1));
		end
		n_msg = $urandom_range(0, 3);
		repeat (n_msg) send_rec(mk(KIND_MSG, rnd64(), rnd64(), 5'($urandom_range(0, 16)), 1'b0));
		if ($urandom_range(0, 3) != 0) begin
			send_rec(mk(KIND_MSG, rnd64(), rnd64(), 5'($urandom_range(0, 16)), 1'b1));
		end
		send_rec(mk(KIND_TAG, rnd64(), rnd64(), 5'($urandom_range(0, 16)), 1'($urandom)));
	endtask

	// Sends the logged streams again with the returned ciphertext and tag in place of the
	// plaintext and the random tag words; some tags get one bit flipped.
	task automatic replay_streams();
		logic [127:0] w;
		block_t b;
		foreach (sent_log[i]) begin
			b = sent_log[i];
			if (b.k == KIND_MSG || b.k == KIND_TAG) begin
				w = '0;
				if (got_q.size() != 0) begin
					w = got_q.pop_front();
				end
				if (b.k == KIND_TAG && $urandom_range(0, 3) == 0) begin
					w[$urandom_range(0, 127)] ^= 1'b1;
				end
				{b.hi, b.lo} = w;
			end
			send_item(b);
		end
	endtask

	initial begin
		logic [63:0] klo, khi;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_KEY_LOW;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_NONCE;
		word_low = '0;
		word_high = '0;
		byte_count = '0;
		last = 1'b0;
		burst_left = 0;
		hold_ask = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_item(mk(KIND_TAG, rnd64(), rnd64(), 5'd16, 1'b1));
		send_item(mk(KIND_MSG, rnd64(), rnd64(), 5'd3, 1'b1));
		wait_idle();
		configure('1, '1, 1'b0);
		send_item(mk(KIND_NONCE, '1, '1, 5'd0, 1'b0));
		send_item(mk(KIND_AD, '1, '1, 5'd0, 1'b0));
		send_item(mk(KIND_AD, '1, '1, 5'd16, 1'b1));
		send_item(mk(KIND_MSG, '1, '1, 5'd16, 1'b0));
		send_item(mk(KIND_MSG, '1, '1, 5'd15, 1'b1));
		send_item(mk(KIND_MSG, '1, '1, 5'd4, 1'b1));
		send_item(mk(KIND_AD, '1, '1, 5'd4, 1'b1));
		send_item(mk(KIND_TAG, '1, '1, 5'd16, 1'b1));
		send_item(mk(KIND_NONCE, '0, '0, 5'd16, 1'b1));
		send_item(mk(KIND_MSG, rnd64(), rnd64(), 5'd0, 1'b1));
		send_item(mk(KIND_TAG, '0, '0, 5'd0, 1'b0));
		send_item(mk(KIND_NONCE, rnd64(), rnd64(), 5'd0, 1'b0));
		send_item(mk(KIND_AD, rnd64(), rnd64(), 5'd0, 1'b1));
		send_item(mk(KIND_NONCE, rnd64(), rnd64(), 5'd0, 1'b0));
		send_item(mk(KIND_AD, rnd64(), rnd64(), 5'd9, 1'b0));
		send_item(mk(KIND_TAG, rnd64(), rnd64(), 5'd0, 1'b0));
		wait_idle();
		configure('0, '0, 1'b1);
		send_item(mk(KIND_NONCE, '0, '0, 5'd0, 1'b0));
		send_item(mk(KIND_AD, rnd64(), rnd64(), 5'd5, 1'b1));
		send_item(mk(KIND_MSG, '0, '0, 5'd16, 1'b0));
		send_item(mk(KIND_MSG, '1, '1, 5'd8, 1'b1));
		send_item(mk(KIND_TAG, '0, '0, 5'd0, 1'b1));

		for (int r = 0; r < 8; r++) begin
			wait_idle();
			klo = (r == 0) ? '0 : (r == 1) ? '1 : rnd64();
			khi = (r == 0) ? '0 : (r == 1) ? '1 : rnd64();
			configure(klo, khi, 1'b0);
			got_q.delete();
			sent_log.delete();
			if (r == 1 || r == 5) begin
				hold_ask++;
			end
			repeat (13) run_stream();
			wait_idle();
			configure(klo, khi, 1'b1);
			replay_streams();
			wait_idle();
			configure(rnd64(), rnd64(), 1'($urandom));
			repeat (70) begin
				send_item(mk(2'($urandom), rnd64(), rnd64(), 5'($urandom_range(0, 16)),
					1'($urandom)));
			end
		end
		wait_idle();

		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
